### rtl/core/abb_pkg.sv
// ----------------------------------------------------------------------------
// abb_pkg
// Shared types and constants for the alpha blit blender: sizes, register
// indexes and the threshold group handed to the blend datapath.
// ----------------------------------------------------------------------------
package abb_pkg;

	localparam int unsigned MAX_DIM   = 4096;
	localparam int unsigned DIM_W     = 13;
	localparam int unsigned POS_W     = 12;
	localparam int unsigned ADDR_W    = 24;
	localparam int unsigned PIX_W     = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 13;

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEST_X     = 3'd0,
		CFG_DEST_Y     = 3'd1,
		CFG_SRC_WIDTH  = 3'd2,
		CFG_SRC_HEIGHT = 3'd3,
		CFG_DST_WIDTH  = 3'd4,
		CFG_DST_HEIGHT = 3'd5,
		CFG_SOLID_THR  = 3'd6,
		CFG_EMPTY_THR  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] solid;
		logic [7:0] empty;
	} abb_thr_t;

endpackage

### rtl/core/abb_blend.sv
// ----------------------------------------------------------------------------
// abb_blend
// Source-over pixel combine: copy above the solid threshold, skip below the
// empty threshold, else per-channel blend with output alpha forced opaque.
// ----------------------------------------------------------------------------
module abb_blend (
	input  logic [31:0]       src_pixel,
	input  logic [31:0]       dst_pixel,
	input  abb_pkg::abb_thr_t thr,
	output logic [31:0]       pixel_out,
	output logic              write_enable
);
	import abb_pkg::*;

	// floor(x/255) for x <= 255*255 as (x + 1 + (x >> 8)) >> 8
	function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		logic [15:0] x;
		logic [16:0] t;
		x = ({8'd0, s} * {8'd0, a}) + ({8'd0, d} * {8'd0, 8'd255 - a});
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return t[15:8];
	endfunction

	logic [7:0] alpha;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	assign alpha = src_pixel[31:24];
	assign red   = blend_ch(src_pixel[7:0],   dst_pixel[7:0],   alpha);
	assign green = blend_ch(src_pixel[15:8],  dst_pixel[15:8],  alpha);
	assign blue  = blend_ch(src_pixel[23:16], dst_pixel[23:16], alpha);

	always_comb begin
		if (alpha > thr.solid) begin
			pixel_out    = src_pixel;
			write_enable = 1'b1;
		end else if (alpha < thr.empty) begin
			pixel_out    = dst_pixel;
			write_enable = 1'b0;
		end else begin
			pixel_out    = {8'hFF, blue, green, red};
			write_enable = 1'b1;
		end
	end

endmodule

### rtl/core/alpha_blit_blender_unit.sv
// ----------------------------------------------------------------------------
// alpha_blit_blender_unit
// Pipeline: input register, then result register, from input beat to result
//   beat; one pixel per clock unless out_stall holds it, in a two-stage
//   pipeline with the address multiply and channel blend in the second stage.
// Reset: registers return to 1x1 sizes at offset 0, thresholds 252 and 4,
//   the walk restarts at the first pixel and both stages empty.
// ----------------------------------------------------------------------------
module alpha_blit_blender_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [abb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [abb_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [abb_pkg::PIX_W-1:0]           src_pixel,
	input  logic [abb_pkg::PIX_W-1:0]           dst_pixel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [abb_pkg::ADDR_W-1:0]          dst_address,
	output logic                                write_enable,
	output logic [abb_pkg::PIX_W-1:0]           pixel_out,
	output logic                                blit_done
);
	import abb_pkg::*;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_DIM_V) ? MAX_DIM_V : v;
	endfunction

	function automatic logic [DIM_W-1:0] clip_len(input logic [DIM_W-1:0] s,
			input logic [DIM_W-1:0] d, input logic [POS_W-1:0] off);
		logic [DIM_W-1:0] room;
		room = d - {1'b0, off};
		if ({1'b0, off} >= d)
			return '0;
		return (s < room) ? s : room;
	endfunction

	logic [POS_W-1:0]  dest_x_q, dest_y_q;
	logic [DIM_W-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [7:0]        solid_q, empty_q;
	logic [POS_W-1:0]  col_q, row_q;
	logic [ADDR_W-1:0] base_q;

	logic              valid_s1;
	logic [ADDR_W-1:0] rel_s1;
	logic [PIX_W-1:0]  src_s1, dst_s1;
	logic              done_s1;

	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [PIX_W-1:0]  pix_s2;
	logic              we_s2;
	logic              done_s2;

	logic [DIM_W-1:0]  pitch, cw, ch;
	logic              region_empty, out_of_range;
	logic [POS_W-1:0]  col_cur, row_cur;
	logic [ADDR_W-1:0] base_cur, rel_cur;
	logic              col_last, row_last, last;
	logic              s1_ready, s2_ready, take, step;
	logic [ADDR_W-1:0] y_offset;
	logic [ADDR_W-1:0] addr_full;
	abb_thr_t          thr;
	logic [PIX_W-1:0]  blend_pix;
	logic              blend_we;

	assign pitch = sat_dim(dst_w_q);
	assign cw    = clip_len(sat_dim(src_w_q), pitch, dest_x_q);
	assign ch    = clip_len(sat_dim(src_h_q), sat_dim(dst_h_q), dest_y_q);

	assign region_empty = (cw == '0) || (ch == '0);
	assign out_of_range = ({1'b0, col_q} >= cw) || ({1'b0, row_q} >= ch);
	assign col_cur  = out_of_range ? '0 : col_q;
	assign row_cur  = out_of_range ? '0 : row_q;
	assign base_cur = out_of_range ? '0 : base_q;
	assign rel_cur  = base_cur + {{(ADDR_W-POS_W){1'b0}}, col_cur};
	assign col_last = ({1'b0, col_cur} == (cw - 13'd1));
	assign row_last = ({1'b0, row_cur} == (ch - 13'd1));
	assign last     = col_last && row_last;

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;
	assign take     = in_valid && s1_ready;
	assign step     = take && !region_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q <= '0;
			dest_y_q <= '0;
			src_w_q  <= 13'd1;
			src_h_q  <= 13'd1;
			dst_w_q  <= 13'd1;
			dst_h_q  <= 13'd1;
			solid_q  <= 8'd252;
			empty_q  <= 8'd4;
			col_q    <= '0;
			row_q    <= '0;
			base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEST_X:     dest_x_q <= cfg_data[POS_W-1:0];
				CFG_DEST_Y:     dest_y_q <= cfg_data[POS_W-1:0];
				CFG_SRC_WIDTH:  src_w_q  <= cfg_data[DIM_W-1:0];
				CFG_SRC_HEIGHT: src_h_q  <= cfg_data[DIM_W-1:0];
				CFG_DST_WIDTH:  dst_w_q  <= cfg_data[DIM_W-1:0];
				CFG_DST_HEIGHT: dst_h_q  <= cfg_data[DIM_W-1:0];
				CFG_SOLID_THR:  solid_q  <= cfg_data[7:0];
				CFG_EMPTY_THR:  empty_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (step) begin
			if (last) begin
				col_q  <= '0;
				row_q  <= '0;
				base_q <= '0;
			end else if (col_last) begin
				col_q  <= '0;
				row_q  <= row_cur + 12'd1;
				base_q <= base_cur + {{(ADDR_W-DIM_W){1'b0}}, pitch};
			end else begin
				col_q  <= col_cur + 12'd1;
				row_q  <= row_cur;
				base_q <= base_cur;
			end
		end
	end

	// stage 1: capture pixel pair and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rel_s1  <= rel_cur;
			src_s1  <= src_pixel;
			dst_s1  <= dst_pixel;
			done_s1 <= last;
		end
	end

	// stage 2: placement offset and pixel combine
	assign y_offset  = {12'd0, dest_y_q} * {11'd0, pitch};
	assign addr_full = rel_s1 + y_offset
		+ {{(ADDR_W-POS_W){1'b0}}, dest_x_q};

	assign thr.solid = solid_q;
	assign thr.empty = empty_q;

	abb_blend u_blend (
		.src_pixel    (src_s1),
		.dst_pixel    (dst_s1),
		.thr          (thr),
		.pixel_out    (blend_pix),
		.write_enable (blend_we)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			addr_s2 <= addr_full;
			pix_s2  <= blend_pix;
			we_s2   <= blend_we;
			done_s2 <= done_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign dst_address  = addr_s2;
	assign pixel_out    = pix_s2;
	assign write_enable = we_s2;
	assign blit_done    = done_s2;

endmodule
